[sv/stable_priority_queue_macros.svh]
// Assertion macros for the stable priority queue.
// Each expects clk and arst_n in scope.
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define SPQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SPQ_ASSERT_IMP(label, ante, cons, msg)
`define SPQ_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

[sv/spq_pkg.sv]
`default_nettype none

package spq_pkg;

	localparam int TAG_W  = 16;
	localparam int PRIO_W = 64;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_SERVE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} spq_status_t;

	typedef struct packed {
		logic                     cmd;
		logic [TAG_W-1:0]         tag;
		logic signed [PRIO_W-1:0] priority_req;
	} spq_req_t;

	typedef struct packed {
		logic [TAG_W-1:0] served_tag;
		spq_status_t      status;
	} spq_rsp_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		logic                     insert;
		logic                     serve;
		logic signed [PRIO_W-1:0] prio;
	} spq_ctl_t;

endpackage

`default_nettype wire

[sv/spq_cell.sv]
`default_nettype none

module spq_cell import spq_pkg::*; #(
	parameter int TW = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire spq_ctl_t                 ctl,
	input  wire logic [TW-1:0]            new_tag,
	input  wire logic                     left_ge,
	input  wire logic                     left_vld,
	input  wire logic [TW-1:0]            left_tag,
	input  wire logic signed [PRIO_W-1:0] left_prio,
	input  wire logic                     right_vld,
	input  wire logic [TW-1:0]            right_tag,
	input  wire logic signed [PRIO_W-1:0] right_prio,
	output logic                          ent_vld,
	output logic [TW-1:0]                 ent_tag,
	output logic signed [PRIO_W-1:0]      ent_prio,
	output logic                          ge
);

	logic                     vld_q;
	logic [TW-1:0]            tag_q;
	logic signed [PRIO_W-1:0] prio_q;

	logic                     vld_d;
	logic [TW-1:0]            tag_d;
	logic signed [PRIO_W-1:0] prio_d;

	// Entry stays ahead of the newcomer on equal priority: FIFO among ties.
	assign ge = vld_q && (prio_q >= ctl.prio);

	always_comb begin
		vld_d  = vld_q;
		tag_d  = tag_q;
		prio_d = prio_q;
		if (ctl.serve) begin
			vld_d  = right_vld;
			tag_d  = right_tag;
			prio_d = right_prio;
		end else if (ctl.insert && !ge) begin
			if (left_ge) begin
				vld_d  = 1'b1;
				tag_d  = new_tag;
				prio_d = ctl.prio;
			end else begin
				vld_d  = left_vld;
				tag_d  = left_tag;
				prio_d = left_prio;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		tag_q  <= tag_d;
		prio_q <= prio_d;
	end

	assign ent_vld  = vld_q;
	assign ent_tag  = tag_q;
	assign ent_prio = prio_q;

endmodule

`default_nettype wire

[sv/stable_priority_queue.sv]
// Channel  Handshake             Payload    Carries
// req      req_valid/req_stall   spq_req_t  insert or serve request
// rsp      rsp_valid/rsp_stall   spq_rsp_t  served tag, or empty/full status
//
// One request per cycle while req_stall is low: the whole chain of cells updates together, the
// path being one 64-bit compare per cell plus the shift select.
// A result appears in rsp in the cycle after its request is taken.
// Reset clears the cell valid bits and the result valid flag; no clearing pass.
// req_stall is high only while a result waits in rsp and rsp_stall is high.
`default_nettype none

`include "stable_priority_queue_macros.svh"

module stable_priority_queue import spq_pkg::*; #(
	parameter int DEPTH    = 16,
	parameter int TAG_BITS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	input  wire spq_req_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	output spq_rsp_t      rsp
);

	// Only the low tag bits that fit the field and TAG_BITS are kept.
	localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

	// Cell chain: entry 0 is the head, sorted by descending priority,
	// arrival order among ties.  Valid bits form a thermometer from the head.
	logic [DEPTH-1:0]         vld;
	logic [DEPTH-1:0]         ge;
	logic [TW-1:0]            tags  [DEPTH];
	logic signed [PRIO_W-1:0] prios [DEPTH];

	spq_ctl_t ctl;
	logic     accept;
	logic     empty;
	logic     full;
	logic     has_rsp;
	spq_rsp_t rsp_d;

	logic     rsp_valid_q;
	spq_rsp_t rsp_q;

	assign empty  = !vld[0];
	assign full   = vld[DEPTH-1];
	assign accept = req_valid && !req_stall;

	// A full insert is dropped; a serve on an empty queue leaves the chain alone.
	assign ctl.insert = accept && (req.cmd == CMD_INSERT) && !full;
	assign ctl.serve  = accept && (req.cmd == CMD_SERVE) && !empty;
	assign ctl.prio   = req.priority_req;

	// Result: every serve, and an insert bounced off a full queue.
	assign has_rsp = accept && ((req.cmd == CMD_SERVE) || full);

	always_comb begin
		rsp_d.served_tag = '0;
		rsp_d.status     = ST_OK;
		if (req.cmd == CMD_SERVE) begin
			if (empty) begin
				rsp_d.status = ST_EMPTY;
			end else begin
				rsp_d.served_tag = TAG_W'(tags[0]);
			end
		end else begin
			rsp_d.status = ST_FULL;
		end
	end

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic                     l_ge;
			logic                     l_vld;
			logic [TW-1:0]            l_tag;
			logic signed [PRIO_W-1:0] l_prio;
			logic                     r_vld;
			logic [TW-1:0]            r_tag;
			logic signed [PRIO_W-1:0] r_prio;

			// Head sees a virtual entry ahead that always outranks the newcomer.
			if (g == 0) begin : g_head
				assign l_ge   = 1'b1;
				assign l_vld  = 1'b0;
				assign l_tag  = '0;
				assign l_prio = '0;
			end else begin : g_mid
				assign l_ge   = ge[g-1];
				assign l_vld  = vld[g-1];
				assign l_tag  = tags[g-1];
				assign l_prio = prios[g-1];
			end

			// Tail shifts in an empty slot on serve.
			if (g == DEPTH-1) begin : g_tail
				assign r_vld  = 1'b0;
				assign r_tag  = '0;
				assign r_prio = '0;
			end else begin : g_body
				assign r_vld  = vld[g+1];
				assign r_tag  = tags[g+1];
				assign r_prio = prios[g+1];
			end

			spq_cell #(
				.TW (TW)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.new_tag    (req.tag[TW-1:0]),
				.left_ge    (l_ge),
				.left_vld   (l_vld),
				.left_tag   (l_tag),
				.left_prio  (l_prio),
				.right_vld  (r_vld),
				.right_tag  (r_tag),
				.right_prio (r_prio),
				.ent_vld    (vld[g]),
				.ent_tag    (tags[g]),
				.ent_prio   (prios[g]),
				.ge         (ge[g])
			);
		end
	endgenerate

	// Result register: takes a new result whenever the old one leaves or is absent.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (has_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (has_rsp) begin
			rsp_q <= rsp_d;
		end
	end

	assign req_stall = rsp_valid_q && rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks on chain ordering and result generation.
	logic             thermo_ok;
	logic             ge_ok;
	logic [DEPTH-2:0] sorted_ok;

	assign thermo_ok = ((vld >> 1) & ~vld) == '0;
	// Entries at or above the request priority sit together at the head.
	assign ge_ok     = ((ge >> 1) & ~ge) == '0;

	generate
		for (g = 0; g < DEPTH-1; g++) begin : g_chk
			assign sorted_ok[g] = !vld[g+1] || (prios[g] >= prios[g+1]);
		end
	endgenerate

	`SPQ_ASSERT_IMP(a_thermo, 1'b1, thermo_ok, "valid bits not contiguous from head")
	`SPQ_ASSERT_IMP(a_ge_prefix, 1'b1, ge_ok, "outranking entries not at the head")
	`SPQ_ASSERT_IMP(a_sorted, 1'b1, &sorted_ok, "chain out of priority order")
	`SPQ_ASSERT_NXT(a_serve_ok, ctl.serve, rsp_valid && (rsp.status == ST_OK),
		"serve on non-empty queue gave no ok result")
	`SPQ_ASSERT_NXT(a_insert_ok, ctl.insert, vld[0], "queue empty after insert")
	`SPQ_ASSERT_NXT(a_full, accept && (req.cmd == CMD_INSERT) && full,
		rsp_valid && (rsp.status == ST_FULL), "full insert not reported")

endmodule

`default_nettype wire

[dv/tb_stable_priority_queue.sv]
`timescale 1ns / 100ps

// Testbench for the stable priority queue.
// A scoreboard class keeps its own sorted copy of the queue: every accepted request
// updates the copy and, where the request yields a result (serve, or insert into a
// full queue), the expected result is queued. Results leaving the block are checked
// in order against that queue. Plain tasks drive the request side; a separate
// process drives rsp_stall.

import spq_pkg::*;

class priority_board;
	typedef struct {
		logic [TAG_W-1:0]         tag;
		logic signed [PRIO_W-1:0] prio;
	} held_entry_t;

	held_entry_t sorted_entries[$];	// highest priority first, ties in arrival order
	spq_rsp_t    due_rsps[$];		// results owed by the block, oldest first
	int          depth;
	int          mismatches;

	function new(int queue_depth);
		depth      = queue_depth;
		mismatches = 0;
	endfunction

	// Apply one accepted request to the shadow queue.
	function void take_request(spq_req_t r);
		held_entry_t e;
		spq_rsp_t    o;
		int          pos;
		o.served_tag = '0;
		if (r.cmd == CMD_INSERT) begin
			if (sorted_entries.size() >= depth) begin
				o.status = ST_FULL;
				due_rsps.push_back(o);
			end else begin
				e.tag  = r.tag;
				e.prio = r.priority_req;
				pos    = 0;
				// new entry goes behind everything of equal or higher priority
				while (pos < sorted_entries.size() && sorted_entries[pos].prio >= e.prio)
					pos++;
				sorted_entries.insert(pos, e);
			end
		end else if (sorted_entries.size() == 0) begin
			o.status = ST_EMPTY;
			due_rsps.push_back(o);
		end else begin
			o.served_tag = sorted_entries[0].tag;
			o.status     = ST_OK;
			void'(sorted_entries.pop_front());
			due_rsps.push_back(o);
		end
	endfunction

	function void check_response(spq_rsp_t got);
		spq_rsp_t want;
		if (due_rsps.size() == 0) begin
			$display("%0t: result with none due: expected nothing, got tag %h status %0d",
				$time, got.served_tag, got.status);
			mismatches++;
			return;
		end
		want = due_rsps.pop_front();
		if (got.served_tag !== want.served_tag) begin
			$display("%0t: served_tag mismatch: expected %h, got %h",
				$time, want.served_tag, got.served_tag);
			mismatches++;
		end
		if (got.status !== want.status) begin
			$display("%0t: status mismatch: expected %0d, got %0d",
				$time, want.status, got.status);
			mismatches++;
		end
	endfunction

	function int outstanding();
		return due_rsps.size();
	endfunction
endclass

module tb_stable_priority_queue;

	localparam int QUEUE_DEPTH = 16;
	localparam int QUIET_LIMIT = 1000;	// cycles with no handshake on either side
	localparam int HOLD_CYCLES = 60;	// long receiver hold-off
	localparam int BURST_LEN   = 40;
	localparam int BURSTS      = 5;

	localparam logic signed [PRIO_W-1:0] PRIO_MAX = {1'b0, {(PRIO_W-1){1'b1}}};
	localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	spq_req_t req;
	logic     rsp_valid;
	logic     rsp_stall;
	spq_rsp_t rsp;

	priority_board board;

	int send_idle_pct;	// chance per request of idling before it
	int stall_pct;		// chance per cycle of the receiver stalling
	int hold_left;		// cycles left of a forced receiver hold-off
	int quiet_cycles;

	int idle_modes[4][2] = '{'{0, 0}, '{50, 0}, '{0, 50}, '{8, 8}};
	int insert_mix[3]    = '{80, 50, 25};

	stable_priority_queue #(
		.DEPTH    (QUEUE_DEPTH),
		.TAG_BITS (TAG_W)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: a forced hold-off, counted here, takes precedence over random stalls.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Monitor. The result seen at an edge belongs to a request taken at an earlier
	// edge, so checking before noting the new request keeps the order right.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				board.check_response(rsp);
			if (req_valid && !req_stall)
				board.take_request(req);
			if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic spq_req_t make_req(logic c, logic [TAG_W-1:0] t,
		logic signed [PRIO_W-1:0] p);
		spq_req_t r;
		r.cmd          = c;
		r.tag          = t;
		r.priority_req = p;
		return r;
	endfunction

	// Random request: priorities lean on a narrow band so ties are common, with
	// extremes and full-width values mixed in. Serves carry random junk fields.
	function automatic spq_req_t random_req(int insert_pct);
		logic                     c;
		logic signed [PRIO_W-1:0] p;
		c = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_SERVE;
		case ($urandom_range(9))
			0, 1, 2, 3: p = PRIO_W'($urandom_range(6)) - PRIO_W'(3);
			4: begin
				case ($urandom_range(3))
					0: p = PRIO_MAX;
					1: p = PRIO_MIN;
					2: p = '0;
					default: p = '1;
				endcase
			end
			default: p = {$urandom, $urandom};
		endcase
		return make_req(c, TAG_W'($urandom), p);
	endfunction

	// Offer one request, idling first at random, and return at the edge it is taken.
	task automatic offer_request(spq_req_t r);
		int gap;
		gap = 0;
		while (gap < 8 && $urandom_range(99) < send_idle_pct)
			gap++;
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
			req       <= make_req(1'($urandom), TAG_W'($urandom), {$urandom, $urandom});
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
	endtask

	// Stop sending and wait until every owed result has come out.
	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
	endtask

	initial begin
		board         = new(QUEUE_DEPTH);
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		rsp_stall     = 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_left     = 0;
		quiet_cycles  = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: serve on empty, fill with extreme and tied priorities,
		// insert into a full queue, then serve part of it back.
		offer_request(make_req(CMD_SERVE, 16'h5a5a, PRIO_MAX));
		offer_request(make_req(CMD_INSERT, 16'h0001, '0));
		offer_request(make_req(CMD_INSERT, 16'hffff, PRIO_MAX));
		offer_request(make_req(CMD_INSERT, 16'h0000, PRIO_MIN));
		offer_request(make_req(CMD_INSERT, 16'h0010, '0));
		offer_request(make_req(CMD_INSERT, 16'h0011, '1));
		offer_request(make_req(CMD_INSERT, 16'h0012, PRIO_MAX));
		offer_request(make_req(CMD_INSERT, 16'h0013, '0));
		offer_request(make_req(CMD_INSERT, 16'h0014, PRIO_MIN));
		for (int i = 0; i < 8; i++)
			offer_request(make_req(CMD_INSERT, TAG_W'(16'h0100 + i), PRIO_W'(i) - PRIO_W'(4)));
		offer_request(make_req(CMD_INSERT, 16'hbeef, PRIO_MAX));	// queue full: dropped
		repeat (7)
			offer_request(make_req(CMD_SERVE, TAG_W'($urandom), {$urandom, $urandom}));
		wait_drained();

		// Long receiver hold-off while requests keep coming: the first result
		// sits in the output register and req_stall must push back.
		hold_left = HOLD_CYCLES;
		repeat (4)
			offer_request(make_req(CMD_SERVE, TAG_W'($urandom), {$urandom, $urandom}));
		repeat (20)
			offer_request(random_req(100));
		wait_drained();

		// Random: each idling mode in turn, each burst with an insert share picked at random
		// from the mix, so both the full and the empty ends are reached.
		foreach (idle_modes[m]) begin
			send_idle_pct = idle_modes[m][0];
			stall_pct     = idle_modes[m][1];
			for (int b = 0; b < BURSTS; b++) begin
				int mix;
				mix = insert_mix[$urandom_range(2)];
				repeat (BURST_LEN)
					offer_request(random_req(mix));
			end
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (board.outstanding() != 0)
			$display("%0t: %0d results never arrived", $time, board.outstanding());
		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[stable_priority_queue.f]
+incdir+sv
sv/spq_pkg.sv
sv/spq_cell.sv
sv/stable_priority_queue.sv
dv/tb_stable_priority_queue.sv
